/* design/qpiw_pkg.sv */
package qpiw_pkg;

    // Frame geometry
    localparam int IMG_SIDE  = 512;
    localparam int COORD_W   = 9;
    localparam int PIX_W     = 8;
    localparam int SIDE_W    = $clog2(IMG_SIDE);
    localparam int ADDR_W    = 2 * SIDE_W;
    localparam int FRAME_N   = IMG_SIDE * IMG_SIDE;

    // Pixel sum and background mean
    localparam int SUM_W     = 26;
    localparam int MEAN_W    = SUM_W + 1 - ADDR_W;

    // Configuration port
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    // Polynomial arithmetic
    localparam int COEF_W    = 32;
    localparam int FRAC_W    = 32;
    localparam int LIN_FRAC  = 16;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int LP_W      = COEF_W + COORD_W + 1;
    localparam int QP_W      = COEF_W + SQ_W + 1;
    localparam int LS_W      = LP_W + 2;
    localparam int QS_W      = QP_W + 2;
    localparam int V_W       = 62;
    localparam int MAG_W     = V_W - FRAC_W;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COL_01,
        REG_COL_23,
        REG_COL_45,
        REG_ROW_67,
        REG_ROW_89,
        REG_ROW_AB
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0001_0000_0000_0000, 64'h0, 64'h0, 64'h0, 64'h0000_0000_0001_0000, 64'h0
    };

    // Action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pixel;
        logic               start_frame;
    } item_t;

endpackage

/* design/qpiw_ram.sv */
module qpiw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: write or registered read, hold data when disabled
    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/quadratic_polynomial_image_warp_unit.sv */
// A read passes the squares, products, partial sums, total and magnitude registers, then the output register.
// Throughput: one transaction per cycle; the whole pipeline stalls while a result waits.
// The frame store is a single-port RAM taking one load write or one read per cycle.
// Reset (aresetn low, synchronous) empties the pipeline, clears the pixel sum and
// restores the identity coefficients; the frame store is not cleared.
module quadratic_polynomial_image_warp_unit import qpiw_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // row [8:0], col [17:9], pixel [25:18], start_frame [26], zero [31:27]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // action [0]
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // warped_pixel [7:0]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // used_background [0]
    output logic                   m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam logic [V_W-1:0]     RND_HALF  = V_W'(1) << (FRAC_W - 1);
    localparam logic [SUM_W:0]     MEAN_HALF = (SUM_W + 1)'(FRAME_N / 2);
    localparam logic [COORD_W:0]   SIDE_C    = (COORD_W + 1)'(IMG_SIDE);
    localparam logic [MAG_W-1:0]   SIDE_M    = MAG_W'(IMG_SIDE);
    localparam logic [MEAN_W-1:0]  PIX_MAX   = MEAN_W'((1 << PIX_W) - 1);

    logic [CFG_W-1:0]         cfg_reg [NUM_REGS];
    logic signed [COEF_W-1:0] coef [2][6];

    item_t                    in_item;
    logic                     adv;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    item_t                    it1_reg, it2_reg, it3_reg, it4_reg, it5_reg;
    logic [SQ_W-1:0]          cc1_reg, rc1_reg, rr1_reg;
    logic signed [LP_W-1:0]   lp2_reg [2][2];
    logic signed [QP_W-1:0]   qp2_reg [2][3];
    logic signed [LS_W-1:0]   ls3_reg [2];
    logic signed [QS_W-1:0]   qs3_reg [2];
    logic signed [V_W-1:0]    val4_reg [2];
    logic [V_W-1:0]           abs5_reg [2];
    logic                     neg5_reg [2];

    logic [V_W-1:0]           rnd [2];
    logic [MAG_W-1:0]         mag [2];
    logic                     in_src [2];
    logic                     src_inside;
    logic                     ld_ok;
    logic                     is_read;
    logic                     ram_en;
    logic [ADDR_W-1:0]        ram_addr;
    logic [PIX_W-1:0]         ram_rdata;

    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;
    logic [SUM_W:0]           mean_full;
    logic [MEAN_W-1:0]        mean_raw;
    logic [PIX_W-1:0]         mean_sat;

    logic                     out_valid_reg;
    logic                     bg_reg;
    logic [PIX_W-1:0]         mean_reg;

    // Unpack the incoming transaction
    assign in_item.action      = s_tuser;
    assign in_item.row         = s_tdata[COORD_W-1:0];
    assign in_item.col         = s_tdata[2*COORD_W-1:COORD_W];
    assign in_item.pixel       = s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
    assign in_item.start_frame = s_tdata[2*COORD_W+PIX_W];

    // Advance every stage together whenever the output slot is free or taken
    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end else if (cfg_valid) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    cfg_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Split registers into signed coefficients
    assign coef[0][0] = cfg_reg[REG_COL_01][COEF_W-1:0];
    assign coef[0][1] = cfg_reg[REG_COL_01][CFG_W-1:COEF_W];
    assign coef[0][2] = cfg_reg[REG_COL_23][COEF_W-1:0];
    assign coef[0][3] = cfg_reg[REG_COL_23][CFG_W-1:COEF_W];
    assign coef[0][4] = cfg_reg[REG_COL_45][COEF_W-1:0];
    assign coef[0][5] = cfg_reg[REG_COL_45][CFG_W-1:COEF_W];
    assign coef[1][0] = cfg_reg[REG_ROW_67][COEF_W-1:0];
    assign coef[1][1] = cfg_reg[REG_ROW_67][CFG_W-1:COEF_W];
    assign coef[1][2] = cfg_reg[REG_ROW_89][COEF_W-1:0];
    assign coef[1][3] = cfg_reg[REG_ROW_89][CFG_W-1:COEF_W];
    assign coef[1][4] = cfg_reg[REG_ROW_AB][COEF_W-1:0];
    assign coef[1][5] = cfg_reg[REG_ROW_AB][CFG_W-1:COEF_W];

    // Pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Arithmetic stages: squares, products, partial sums, total, magnitude
    always_ff @(posedge aclk) begin
        if (adv) begin
            it1_reg <= in_item;
            cc1_reg <= in_item.col * in_item.col;
            rc1_reg <= in_item.row * in_item.col;
            rr1_reg <= in_item.row * in_item.row;

            it2_reg <= it1_reg;
            it3_reg <= it2_reg;
            it4_reg <= it3_reg;
            it5_reg <= it4_reg;

            for (int p = 0; p < 2; p++) begin
                lp2_reg[p][0] <= coef[p][1] * $signed({1'b0, it1_reg.col});
                lp2_reg[p][1] <= coef[p][2] * $signed({1'b0, it1_reg.row});
                qp2_reg[p][0] <= coef[p][3] * $signed({1'b0, cc1_reg});
                qp2_reg[p][1] <= coef[p][4] * $signed({1'b0, rc1_reg});
                qp2_reg[p][2] <= coef[p][5] * $signed({1'b0, rr1_reg});

                ls3_reg[p] <= LS_W'(coef[p][0]) + LS_W'(lp2_reg[p][0])
                            + LS_W'(lp2_reg[p][1]);
                qs3_reg[p] <= QS_W'(qp2_reg[p][0]) + QS_W'(qp2_reg[p][1])
                            + QS_W'(qp2_reg[p][2]);

                val4_reg[p] <= (V_W'(ls3_reg[p]) <<< LIN_FRAC) + V_W'(qs3_reg[p]);

                neg5_reg[p] <= val4_reg[p][V_W-1];
                abs5_reg[p] <= val4_reg[p][V_W-1] ? V_W'(-val4_reg[p])
                                                  : V_W'(val4_reg[p]);
            end
        end
    end

    // Round half away from zero and check the source lies in the frame
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            rnd[p]    = abs5_reg[p] + RND_HALF;
            mag[p]    = rnd[p][V_W-1:FRAC_W];
            in_src[p] = (mag[p] < SIDE_M) && (!neg5_reg[p] || mag[p] == '0);
        end
    end

    assign src_inside = in_src[0] && in_src[1];
    assign is_read    = (it5_reg.action == ACT_READ);
    assign ld_ok      = ({1'b0, it5_reg.row} < SIDE_C) && ({1'b0, it5_reg.col} < SIDE_C);

    // Frame store access: loads write, reads of an inside source fetch
    assign ram_en   = adv && v5_reg && (is_read ? src_inside : ld_ok);
    assign ram_addr = is_read ? {mag[1][SIDE_W-1:0], mag[0][SIDE_W-1:0]}
                              : {it5_reg.row[SIDE_W-1:0], it5_reg.col[SIDE_W-1:0]};

    qpiw_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_N)
    ) u_frame_ram (
        .clk   (aclk),
        .en    (ram_en),
        .we    (!is_read),
        .addr  (ram_addr),
        .wdata (it5_reg.pixel),
        .rdata (ram_rdata)
    );

    // Pixel sum, cleared on the first load of a frame
    assign sum_next = (it5_reg.start_frame ? '0 : sum_reg) + SUM_W'(it5_reg.pixel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (adv && v5_reg && !is_read && ld_ok) begin
            sum_reg <= sum_next;
        end
    end

    // Rounded frame mean, saturated to the pixel range
    assign mean_full = (SUM_W + 1)'(sum_reg) + MEAN_HALF;
    assign mean_raw  = mean_full[SUM_W:ADDR_W];
    assign mean_sat  = (mean_raw > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : mean_raw[PIX_W-1:0];

    // Output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= v5_reg && is_read;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bg_reg   <= !src_inside;
            mean_reg <= mean_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = bg_reg;
    assign m_tdata  = bg_reg ? mean_reg : ram_rdata;

endmodule

/* design/qpiw_checker.sv */
module qpiw_checker import qpiw_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Drop input ready only when a result is stuck
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input ready low without output back-pressure");

    // Empty the pipeline on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A new result appears only after the pipeline advanced
    a_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid) && $past(aresetn) |-> $past(s_tready))
        else $error("result appeared during a stall");

endmodule

bind quadratic_polynomial_image_warp_unit qpiw_checker u_qpiw_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

/* tb/quadratic_polynomial_image_warp_unit_tb.sv */
`timescale 1ns / 1ps

module quadratic_polynomial_image_warp_unit_tb;
    import qpiw_pkg::*;

    localparam int     COORD_MAX     = (1 << COORD_W) - 1;
    localparam int     PIX_MAX       = (1 << PIX_W) - 1;
    localparam longint ROUND_HALF    = 64'sd1 << (FRAC_W - 1);
    localparam int     DRAIN_CYCLES  = 10;
    localparam int     RANDOM_PHASES = 6;
    localparam int     PHASE_ITEMS   = 70;
    localparam int     BURST_ITEMS   = 80;
    // full-scale loads that build up the pixel sum before the background reads
    localparam int     SUM_LOADS     = 96;

    typedef bit [CFG_W-1:0] coef_set_t [NUM_REGS];

    typedef enum {
        TERM_CONST,
        TERM_LINEAR,
        TERM_QUAD
    } term_kind_t;

    typedef struct {
        bit [PIX_W-1:0] pixel;
        bit             background;
    } warp_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Shadow of the block's state
    bit [PIX_W-1:0] frame_copy [FRAME_N];
    bit             frame_written [FRAME_N];
    bit [SUM_W-1:0] sum_copy;
    coef_set_t      identity_coefs = '{
        64'h0001_0000_0000_0000, 64'h0, 64'h0, 64'h0, 64'h0000_0000_0001_0000, 64'h0
    };
    coef_set_t      coef_regs;

    warp_result_t   pending_warps [$];
    warp_result_t   oldest_warp;
    bit             idling = 1'b1;
    int             stall_left;
    int             n_errors, n_loads, n_reads, n_background, n_config;

    quadratic_polynomial_image_warp_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Signed 32-bit half of a coefficient register
    function automatic longint coef_half(bit [CFG_W-1:0] r, bit upper);
        logic signed [COEF_W-1:0] h;
        h = upper ? r[63:32] : r[31:0];
        return h;
    endfunction

    // Evaluate one polynomial exactly in Q.32 and round half away from zero
    function automatic longint poly_coord(bit [CFG_W-1:0] r01, bit [CFG_W-1:0] r23,
                                          bit [CFG_W-1:0] r45, longint row, longint col);
        longint v;
        v = (coef_half(r01, 0) + coef_half(r01, 1) * col + coef_half(r23, 0) * row) * 65536;
        v += coef_half(r23, 1) * col * col + coef_half(r45, 0) * row * col
             + coef_half(r45, 1) * row * row;
        if (v >= 0) begin
            return (v + ROUND_HALF) >>> FRAC_W;
        end
        return -((-v + ROUND_HALF) >>> FRAC_W);
    endfunction

    // Source position of an output pixel; returns 1 when it lies inside the frame
    function automatic bit warp_source(bit [COORD_W-1:0] row, bit [COORD_W-1:0] col,
                                       output longint sx, output longint sy);
        sx = poly_coord(coef_regs[REG_COL_01], coef_regs[REG_COL_23], coef_regs[REG_COL_45],
                        row, col);
        sy = poly_coord(coef_regs[REG_ROW_67], coef_regs[REG_ROW_89], coef_regs[REG_ROW_AB],
                        row, col);
        return sx >= 0 && sx < IMG_SIDE && sy >= 0 && sy < IMG_SIDE;
    endfunction

    // Frame mean rounded half up, clamped to the pixel range
    function automatic bit [PIX_W-1:0] background_level();
        longint mean;
        mean = (longint'(sum_copy) + FRAME_N / 2) / FRAME_N;
        return (mean > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : mean[PIX_W-1:0];
    endfunction

    // Update the shadow state for one accepted transaction and queue any result
    task automatic apply_transaction(item_t it);
        longint       sx, sy;
        warp_result_t res;
        if (it.action == ACT_LOAD) begin
            if (it.row < IMG_SIDE && it.col < IMG_SIDE) begin
                frame_copy[it.row * IMG_SIDE + it.col]    = it.pixel;
                frame_written[it.row * IMG_SIDE + it.col] = 1'b1;
                if (it.start_frame) begin
                    sum_copy = '0;
                end
                sum_copy += it.pixel;
            end
            n_loads++;
        end else begin
            if (warp_source(it.row, it.col, sx, sy)) begin
                res.pixel      = frame_copy[sy * IMG_SIDE + sx];
                res.background = 1'b0;
            end else begin
                res.pixel      = background_level();
                res.background = 1'b1;
                n_background++;
            end
            n_reads++;
            pending_warps.push_back(res);
        end
    endtask

    // Drive one transaction from a falling edge and hold it until accepted
    task automatic send_item(item_t it);
        if (idling && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            s_tdata  = $urandom;
            s_tuser  = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W - 27){1'b0}}, it.start_frame, it.pixel, it.col, it.row};
        s_tuser  = it.action;
        do @(posedge aclk); while (s_tready !== 1'b1);
        apply_transaction(it);
        @(negedge aclk);
    endtask

    task automatic send_load(int row, int col, int pixel, bit start);
        item_t it;
        it = '{action: ACT_LOAD, row: COORD_W'(row), col: COORD_W'(col),
               pixel: PIX_W'(pixel), start_frame: start};
        send_item(it);
    endtask

    // Read one output pixel; fill its source first if the frame lacks it there
    task automatic request_read(int row, int col);
        longint sx, sy;
        item_t  it;
        if (warp_source(COORD_W'(row), COORD_W'(col), sx, sy)
            && !frame_written[sy * IMG_SIDE + sx]) begin
            send_load(sy[COORD_W-1:0], sx[COORD_W-1:0], $urandom_range(0, PIX_MAX), 1'b0);
        end
        it = '{action: ACT_READ, row: COORD_W'(row), col: COORD_W'(col),
               pixel: PIX_W'($urandom_range(0, PIX_MAX)),
               start_frame: 1'($urandom_range(0, 1))};
        send_item(it);
    endtask

    // Drop valid and wait for every outstanding result plus the pipeline depth
    task automatic settle();
        s_tvalid = 1'b0;
        while (pending_warps.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, bit [CFG_W-1:0] value);
        settle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        coef_regs[idx] = value;
        n_config++;
        @(negedge aclk);
        cfg_valid = 1'b0;
        cfg_data  = {$urandom, $urandom};
    endtask

    task automatic load_coefficients(coef_set_t set);
        foreach (set[i]) begin
            write_reg(cfg_idx_t'(i), set[i]);
        end
    endtask

    function automatic bit [COEF_W-1:0] mild_term(term_kind_t kind);
        case (kind)
            TERM_CONST:  return $urandom_range(0, 664 << 16) - (64 << 16);
            TERM_LINEAR: return $urandom_range(0, 3 << 16) - (3 << 15);
            default:     return $urandom_range(0, 1 << 22) - (1 << 21);
        endcase
    endfunction

    // Mostly maps that keep sources near the frame, sometimes raw words
    function automatic coef_set_t random_coef_set();
        coef_set_t s;
        if ($urandom_range(0, 3) == 0) begin
            foreach (s[i]) s[i] = {$urandom, $urandom};
        end else begin
            s[REG_COL_01] = {mild_term(TERM_LINEAR), mild_term(TERM_CONST)};
            s[REG_COL_23] = {mild_term(TERM_QUAD), mild_term(TERM_LINEAR)};
            s[REG_COL_45] = {mild_term(TERM_QUAD), mild_term(TERM_QUAD)};
            s[REG_ROW_67] = {mild_term(TERM_LINEAR), mild_term(TERM_CONST)};
            s[REG_ROW_89] = {mild_term(TERM_QUAD), mild_term(TERM_LINEAR)};
            s[REG_ROW_AB] = {mild_term(TERM_QUAD), mild_term(TERM_QUAD)};
        end
        return s;
    endfunction

    task automatic random_traffic(int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 35) begin
                send_load($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, PIX_MAX), $urandom_range(0, 19) == 0);
            end else begin
                request_read($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            end
        end
    endtask

    // Reset coefficients give the identity map: corners, mid-frame, write-then-read
    task automatic test_identity_map();
        send_load(0, 0, 8'h00, 1'b1);
        send_load(0, COORD_MAX, PIX_MAX, 1'b0);
        send_load(COORD_MAX, 0, 8'hAA, 1'b0);
        send_load(COORD_MAX, COORD_MAX, 8'h55, 1'b0);
        send_load(9'h0AA, 9'h155, 8'hC3, 1'b1);
        request_read(0, 0);
        request_read(0, COORD_MAX);
        request_read(COORD_MAX, 0);
        request_read(COORD_MAX, COORD_MAX);
        request_read(9'h0AA, 9'h155);
        send_load(9'h155, 9'h0AA, 8'h3C, 1'b0);
        request_read(9'h155, 9'h0AA);
    endtask

    // Half-pixel offsets around the frame edges
    task automatic test_rounding_and_fill();
        // column minus a half: column 0 rounds away to -1
        write_reg(REG_COL_01, {32'h0001_0000, 32'hFFFF_8000});
        request_read(5, 0);
        request_read(5, 1);
        // column plus a half: the last column rounds out to the side
        write_reg(REG_COL_01, {32'h0001_0000, 32'h0000_8000});
        request_read(5, COORD_MAX);
        request_read(5, 0);
        // just under a half rounds towards zero
        write_reg(REG_COL_01, {32'h0001_0000, 32'hFFFF_8001});
        request_read(5, 0);
        write_reg(REG_COL_01, identity_coefs[REG_COL_01]);
        // source row one above the top
        write_reg(REG_ROW_67, {32'h0000_0000, 32'hFFFF_0000});
        request_read(0, 7);
        request_read(COORD_MAX, 7);
        write_reg(REG_ROW_67, identity_coefs[REG_ROW_67]);
    endtask

    task automatic test_extreme_coefficients();
        coef_set_t      s;
        bit [CFG_W-1:0] extremes [4] = '{
            64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000, {CFG_W{1'b1}}, 64'h0
        };
        foreach (extremes[e]) begin
            foreach (s[i]) s[i] = extremes[e];
            load_coefficients(s);
            request_read(0, 0);
            request_read(COORD_MAX, COORD_MAX);
        end
        // gentle curvature: col^2/1024 for the column, row/2 + row*col/2048 for the row
        foreach (s[i]) s[i] = '0;
        s[REG_COL_23] = {32'h0040_0000, 32'h0};
        s[REG_ROW_89] = {32'h0, 32'h0000_8000};
        s[REG_ROW_AB] = {32'h0, 32'h0020_0000};
        load_coefficients(s);
        request_read(COORD_MAX, COORD_MAX);
        request_read(100, 300);
    endtask

    // Random maps, each phase with one pause for the block to drain
    task automatic test_random_warps();
        coef_set_t s;
        int        pause_at;
        repeat (RANDOM_PHASES) begin
            s = random_coef_set();
            load_coefficients(s);
            pause_at = $urandom_range(1, PHASE_ITEMS - 1);
            random_traffic(pause_at);
            settle();
            random_traffic(PHASE_ITEMS - pause_at);
        end
    endtask

    // Full-scale loads from a fresh frame start; reads far off the frame see the mean
    task automatic test_background_mean();
        coef_set_t s;
        int        n;
        s = identity_coefs;
        s[REG_COL_01] = {32'h0001_0000, 32'h7FFF_0000};
        load_coefficients(s);
        idling = 1'b0;
        for (n = 1; n <= SUM_LOADS; n++) begin
            send_load((n - 1) / IMG_SIDE, (n - 1) % IMG_SIDE, PIX_MAX, n == 1);
            if (n % 32 == 0) begin
                request_read($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            end
        end
    endtask

    // Back-to-back traffic with no gaps on either side
    task automatic test_final_burst();
        coef_set_t s;
        s = random_coef_set();
        load_coefficients(s);
        random_traffic(BURST_ITEMS);
    endtask

    // Receiver: stall in short bursts while idling is enabled
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_warps.size() == 0) begin
                $display("%0t: unexpected result, warped_pixel %0d used_background %0d",
                         $time, m_tdata, m_tuser);
                n_errors++;
            end else begin
                oldest_warp = pending_warps.pop_front();
                if (m_tdata !== oldest_warp.pixel) begin
                    $display("%0t: warped_pixel expected %0d, got %0d",
                             $time, oldest_warp.pixel, m_tdata);
                    n_errors++;
                end
                if (m_tuser !== oldest_warp.background) begin
                    $display("%0t: used_background expected %0d, got %0d",
                             $time, oldest_warp.background, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        coef_regs = identity_coefs;
        sum_copy  = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_identity_map();
        test_rounding_and_fill();
        test_extreme_coefficients();
        test_random_warps();
        test_background_mean();
        test_final_burst();
        settle();

        $display("Run: %0d loads, %0d warped reads (%0d from background), %0d register writes.",
                 n_loads, n_reads, n_background, n_config);
        $display("Maps: identity, half-pixel edges, extreme and random coefficients, frame mean.");
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
